// ----- src/pcrrs_pkg.sv -----
`timescale 1ns / 1ps

package pcrrs_pkg;

  localparam int NUM_CPUS    = 4;
  localparam int MAX_THREADS = 64;

  localparam int CMD_W    = 2;
  localparam int THREAD_W = 6;
  localparam int AFF_W    = 4;
  localparam int CPU_W    = 2;
  localparam int BUDGET_W = 16;
  localparam int LINK_W   = THREAD_W + 1;

  typedef logic [LINK_W-1:0]   link_t;
  typedef logic [THREAD_W-1:0] tid_t;
  typedef logic [CPU_W-1:0]    cpu_t;
  typedef logic [BUDGET_W-1:0] budget_t;

  localparam link_t   NULL_LINK    = LINK_W'(MAX_THREADS);
  localparam budget_t BUDGET_RESET = BUDGET_W'(2);

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE  = 2'd0,
    CMD_DEQUEUE  = 2'd1,
    CMD_SCHEDULE = 2'd2,
    CMD_TICK     = 2'd3
  } cmd_e;

endpackage

// ----- src/per_cpu_round_robin_scheduler.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_stall_o  command, thread_id, no_affinity, affinity, cpu
// out       output     out_valid_o / out_stall_i status, next_tid, chosen_is_idle, switched
// cfg       input      cfg_wr_en_i              cfg_wr_data_i (time slice length)
//
// One request is taken per cycle unless stalled; the result register loads when it executes.
// Each request runs in one pass through the logic between the input register and the
// result register; the link memories are read at transfer time with write bypass.
// Reset clears queues, ready bits and CPU state at once; link memories need no clearing.
// A stalled result holds the input stage only once the input register is also full.
module per_cpu_round_robin_scheduler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_wr_en_i,
  input  logic [pcrrs_pkg::BUDGET_W-1:0] cfg_wr_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pcrrs_pkg::CMD_W-1:0]    command_i,
  input  logic [pcrrs_pkg::THREAD_W-1:0] thread_id_i,
  input  logic                          no_affinity_i,
  input  logic [pcrrs_pkg::AFF_W-1:0]    affinity_i,
  input  logic [pcrrs_pkg::CPU_W-1:0]    cpu_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          status_o,
  output logic [pcrrs_pkg::THREAD_W-1:0] next_tid_o,
  output logic                          chosen_is_idle_o,
  output logic                          switched_o
);
  import pcrrs_pkg::*;

  budget_t slice_ticks_q;

  logic [MAX_THREADS-1:0] ready_q, ready_d;
  link_t   head_q       [NUM_CPUS];
  link_t   head_d       [NUM_CPUS];
  link_t   tail_q       [NUM_CPUS];
  link_t   tail_d       [NUM_CPUS];
  tid_t    run_thread_q [NUM_CPUS];
  tid_t    run_thread_d [NUM_CPUS];
  logic    run_idle_q   [NUM_CPUS];
  logic    run_idle_d   [NUM_CPUS];
  logic    run_valid_q  [NUM_CPUS];
  logic    run_valid_d  [NUM_CPUS];
  budget_t budget_q     [NUM_CPUS];
  budget_t budget_d     [NUM_CPUS];

  link_t nxt_mem  [MAX_THREADS];
  link_t prv_mem  [MAX_THREADS];
  cpu_t  home_mem [MAX_THREADS];

  logic  nxt_we, prv_we, home_we;
  tid_t  nxt_wa, prv_wa, home_wa;
  link_t nxt_wd, prv_wd;
  cpu_t  home_wd;
  tid_t  nxt_ra, prv_ra, home_ra;
  link_t nxt_rd_q, prv_rd_q;
  cpu_t  home_rd_q;

  logic s1_valid_q;
  cmd_e cmd_q;
  tid_t tid_q;
  logic noaff_q;
  logic [AFF_W-1:0] aff_q;
  cpu_t cpu_q;

  logic out_valid_q;
  logic status_q, status_d;
  tid_t chosen_q, chosen_d;
  logic idle_q, idle_d;
  logic sw_q, sw_d;

  logic in_xfer, exec;
  logic cpu_ok, aff_ok;
  cpu_t enq_cpu;

  assign exec       = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !exec;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign cpu_ok  = 32'(cpu_q) < NUM_CPUS;
  assign aff_ok  = noaff_q || (32'(aff_q) < NUM_CPUS);
  assign enq_cpu = noaff_q ? cpu_q : aff_q[CPU_W-1:0];

  // Read addresses follow the state as it stands after the request now executing.
  assign prv_ra  = thread_id_i;
  assign nxt_ra  = (cmd_e'(command_i) == CMD_SCHEDULE) ? head_d[cpu_i][THREAD_W-1:0]
                                                       : thread_id_i;
  assign home_ra = (cmd_e'(command_i) == CMD_SCHEDULE) ? run_thread_d[cpu_i] : thread_id_i;

  always_comb begin
    link_t p, n, last, t1, h1, nh;
    cpu_t  q, qr, c;
    tid_t  t, r;
    logic  requeue;

    ready_d      = ready_q;
    head_d       = head_q;
    tail_d       = tail_q;
    run_thread_d = run_thread_q;
    run_idle_d   = run_idle_q;
    run_valid_d  = run_valid_q;
    budget_d     = budget_q;
    nxt_we  = 1'b0;
    nxt_wa  = '0;
    nxt_wd  = NULL_LINK;
    prv_we  = 1'b0;
    prv_wa  = '0;
    prv_wd  = NULL_LINK;
    home_we = 1'b0;
    home_wa = '0;
    home_wd = '0;
    status_d = 1'b0;
    chosen_d = '0;
    idle_d   = 1'b0;
    sw_d     = 1'b0;
    p = NULL_LINK;
    n = NULL_LINK;
    last = NULL_LINK;
    t1 = NULL_LINK;
    h1 = NULL_LINK;
    nh = NULL_LINK;
    q = '0;
    qr = '0;
    c = cpu_q;
    t = tid_q;
    r = '0;
    requeue = 1'b0;

    if (exec) begin
      if (!cpu_ok) begin
        status_d = 1'b1;
      end else begin
        case (cmd_q)
          CMD_ENQUEUE: begin
            if (ready_q[t] || !aff_ok) begin
              status_d = 1'b1;
            end else begin
              q = enq_cpu;
              last = tail_q[q];
              prv_we = 1'b1;
              prv_wa = t;
              prv_wd = last;
              if (last != NULL_LINK) begin
                nxt_we = 1'b1;
                nxt_wa = last[THREAD_W-1:0];
                nxt_wd = LINK_W'(t);
              end else begin
                head_d[q] = LINK_W'(t);
              end
              tail_d[q] = LINK_W'(t);
              ready_d[t] = 1'b1;
              home_we = 1'b1;
              home_wa = t;
              home_wd = q;
            end
          end
          CMD_DEQUEUE: begin
            if (!ready_q[t]) begin
              status_d = 1'b1;
            end else begin
              q = home_rd_q;
              if (32'(q) >= NUM_CPUS) begin
                q = '0;
              end
              // The head has no predecessor and the tail no successor, whatever
              // the link memories hold for them.
              p = (head_q[q] == LINK_W'(t)) ? NULL_LINK : prv_rd_q;
              n = (tail_q[q] == LINK_W'(t)) ? NULL_LINK : nxt_rd_q;
              if (p != NULL_LINK) begin
                nxt_we = 1'b1;
                nxt_wa = p[THREAD_W-1:0];
                nxt_wd = n;
              end else begin
                head_d[q] = n;
              end
              if (n != NULL_LINK) begin
                prv_we = 1'b1;
                prv_wa = n[THREAD_W-1:0];
                prv_wd = p;
              end else begin
                tail_d[q] = p;
              end
              ready_d[t] = 1'b0;
            end
          end
          CMD_SCHEDULE: begin
            if (!(run_valid_q[c] && (budget_q[c] != '0))) begin
              r = run_thread_q[c];
              requeue = run_valid_q[c] && !run_idle_q[c] && !ready_q[r];
              qr = home_rd_q;
              if (32'(qr) >= NUM_CPUS) begin
                qr = c;
              end
              t1 = tail_q[qr];
              if (requeue) begin
                prv_we = 1'b1;
                prv_wa = r;
                prv_wd = t1;
                if (t1 != NULL_LINK) begin
                  nxt_we = 1'b1;
                  nxt_wa = t1[THREAD_W-1:0];
                  nxt_wd = LINK_W'(r);
                end else begin
                  head_d[qr] = LINK_W'(r);
                end
                tail_d[qr] = LINK_W'(r);
                ready_d[r] = 1'b1;
                home_we = 1'b1;
                home_wa = r;
                home_wd = qr;
              end
              h1 = head_d[c];
              if (h1 != NULL_LINK) begin
                nh = (requeue && (t1 == h1)) ? LINK_W'(r) : nxt_rd_q;
                n = (tail_d[c] == h1) ? NULL_LINK : nh;
                head_d[c] = n;
                if (n == NULL_LINK) begin
                  tail_d[c] = NULL_LINK;
                end
                ready_d[h1[THREAD_W-1:0]] = 1'b0;
                run_thread_d[c] = h1[THREAD_W-1:0];
                run_idle_d[c] = 1'b0;
              end else begin
                run_thread_d[c] = '0;
                run_idle_d[c] = 1'b1;
              end
              run_valid_d[c] = 1'b1;
              budget_d[c] = slice_ticks_q;
              sw_d = 1'b1;
            end
            idle_d = run_idle_d[c];
            chosen_d = run_idle_d[c] ? '0 : run_thread_d[c];
          end
          CMD_TICK: begin
            if (run_valid_q[c] && (budget_q[c] != '0)) begin
              budget_d[c] = budget_q[c] - BUDGET_W'(1);
            end
          end
          default: begin
            status_d = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_ticks_q <= BUDGET_RESET;
      ready_q <= '0;
      for (int i = 0; i < NUM_CPUS; i++) begin
        head_q[i]       <= NULL_LINK;
        tail_q[i]       <= NULL_LINK;
        run_thread_q[i] <= '0;
        run_idle_q[i]   <= 1'b0;
        run_valid_q[i]  <= 1'b0;
        budget_q[i]     <= '0;
      end
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        slice_ticks_q <= cfg_wr_data_i;
      end
      ready_q      <= ready_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      run_thread_q <= run_thread_d;
      run_idle_q   <= run_idle_d;
      run_valid_q  <= run_valid_d;
      budget_q     <= budget_d;
      s1_valid_q   <= in_xfer || (s1_valid_q && !exec);
      out_valid_q  <= exec || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q   <= cmd_e'(command_i);
      tid_q   <= thread_id_i;
      noaff_q <= no_affinity_i;
      aff_q   <= affinity_i;
      cpu_q   <= cpu_i;
    end
    if (exec) begin
      status_q <= status_d;
      chosen_q <= chosen_d;
      idle_q   <= idle_d;
      sw_q     <= sw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    if (in_xfer) begin
      if (nxt_we && (nxt_wa == nxt_ra)) begin
        nxt_rd_q <= nxt_wd;
      end else begin
        nxt_rd_q <= nxt_mem[nxt_ra];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    if (in_xfer) begin
      if (prv_we && (prv_wa == prv_ra)) begin
        prv_rd_q <= prv_wd;
      end else begin
        prv_rd_q <= prv_mem[prv_ra];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (home_we) begin
      home_mem[home_wa] <= home_wd;
    end
    if (in_xfer) begin
      if (home_we && (home_wa == home_ra)) begin
        home_rd_q <= home_wd;
      end else begin
        home_rd_q <= home_mem[home_ra];
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign next_tid_o       = chosen_q;
  assign chosen_is_idle_o = idle_q;
  assign switched_o       = sw_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> out_valid_q)
    else $error("Executed request did not reach the result register.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && cpu_ok && (cmd_q == CMD_SCHEDULE)) |=> run_valid_q[$past(cpu_q)])
    else $error("CPU has no running thread after a schedule.");

  for (genvar g = 0; g < NUM_CPUS; g++) begin : g_cpu_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      (head_q[g] == NULL_LINK) == (tail_q[g] == NULL_LINK))
      else $error("Queue head and tail disagree on emptiness.");

    assert property (@(posedge clk_i) disable iff (!rst_ni)
      (exec && (cmd_q == CMD_TICK)) |=> (budget_q[g] <= $past(budget_q[g])))
      else $error("Timer tick raised a budget.");
  end

endmodule
